[sv/rvalu_pkg.sv]
`timescale 1ns / 1ps
package rvalu_pkg;

   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_REG32  = 7'h3B;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_IMM32  = 7'h1B;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_JAL    = 7'h6F;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;
   localparam logic [5:0] F6_BASE = 6'h00;
   localparam logic [5:0] F6_SRA  = 6'h10;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_SYS_RESERVED = 3'd4;

   localparam logic [63:0] LINK_OFFSET = 64'd4;

   typedef enum logic [4:0] {
      ALU_ZERO,
      ALU_ADD,
      ALU_SUB,
      ALU_SLL,
      ALU_SLT,
      ALU_SLTU,
      ALU_XOR,
      ALU_SRL,
      ALU_SRA,
      ALU_OR,
      ALU_AND,
      ALU_ADDW,
      ALU_SUBW,
      ALU_SLLW,
      ALU_SRLW,
      ALU_SRAW,
      ALU_PASS_B,
      ALU_LINK
   } alu_op_type;

   typedef enum logic [2:0] {
      BR_NONE,
      BR_EQ,
      BR_NE,
      BR_LT,
      BR_GE,
      BR_LTU,
      BR_GEU
   } branch_type;

   typedef struct packed {
      alu_op_type alu_op;
      logic       a_sel_pc;
      logic       b_sel_imm;
      branch_type br_cond;
      logic       unsupported;
   } ctrl_type;

   typedef struct packed {
      logic [31:0] instr_word;
      logic [63:0] src1_value;
      logic [63:0] src2_value;
      logic [63:0] imm_value;
      logic [63:0] pc_value;
   } req_type;

   typedef struct packed {
      logic [63:0] result_value;
      logic        branch_taken;
      logic        unsupported;
   } rsp_type;

endpackage

[sv/rvalu_decode.sv]
`timescale 1ns / 1ps
module rvalu_decode
   import rvalu_pkg::*;
(
   input  logic [31:0] instr_word,
   output ctrl_type    ctrl
);

   logic [6:0] opcode;
   logic [2:0] funct3;
   logic [6:0] funct7;
   logic [5:0] funct6;

   assign opcode = instr_word[6:0];
   assign funct3 = instr_word[14:12];
   assign funct7 = instr_word[31:25];
   assign funct6 = instr_word[31:26];

   always_comb begin
      ctrl.alu_op      = ALU_ZERO;
      ctrl.a_sel_pc    = 1'b0;
      ctrl.b_sel_imm   = 1'b0;
      ctrl.br_cond     = BR_NONE;
      ctrl.unsupported = 1'b0;

      case (opcode)
         OP_REG: begin
            if (funct7 == F7_BASE) begin
               case (funct3)
                  F3_ADD:  ctrl.alu_op = ALU_ADD;
                  F3_SLL:  ctrl.alu_op = ALU_SLL;
                  F3_SLT:  ctrl.alu_op = ALU_SLT;
                  F3_SLTU: ctrl.alu_op = ALU_SLTU;
                  F3_XOR:  ctrl.alu_op = ALU_XOR;
                  F3_SR:   ctrl.alu_op = ALU_SRL;
                  F3_OR:   ctrl.alu_op = ALU_OR;
                  default: ctrl.alu_op = ALU_AND;
               endcase
            end else if (funct7 == F7_ALT && funct3 == F3_ADD) begin
               ctrl.alu_op = ALU_SUB;
            end else if (funct7 == F7_ALT && funct3 == F3_SR) begin
               ctrl.alu_op = ALU_SRA;
            end else begin
               ctrl.unsupported = 1'b1;
            end
         end
         OP_REG32: begin
            if (funct7 == F7_BASE && funct3 == F3_ADD) begin
               ctrl.alu_op = ALU_ADDW;
            end else if (funct7 == F7_BASE && funct3 == F3_SLL) begin
               ctrl.alu_op = ALU_SLLW;
            end else if (funct7 == F7_BASE && funct3 == F3_SR) begin
               ctrl.alu_op = ALU_SRLW;
            end else if (funct7 == F7_ALT && funct3 == F3_ADD) begin
               ctrl.alu_op = ALU_SUBW;
            end else if (funct7 == F7_ALT && funct3 == F3_SR) begin
               ctrl.alu_op = ALU_SRAW;
            end else begin
               ctrl.unsupported = 1'b1;
            end
         end
         OP_IMM: begin
            ctrl.b_sel_imm = 1'b1;
            case (funct3)
               F3_ADD:  ctrl.alu_op = ALU_ADD;
               F3_SLL: begin
                  if (funct6 == F6_BASE) ctrl.alu_op = ALU_SLL;
                  else ctrl.unsupported = 1'b1;
               end
               F3_SLT:  ctrl.alu_op = ALU_SLT;
               F3_SLTU: ctrl.alu_op = ALU_SLTU;
               F3_XOR:  ctrl.alu_op = ALU_XOR;
               F3_SR: begin
                  if (funct6 == F6_BASE) ctrl.alu_op = ALU_SRL;
                  else if (funct6 == F6_SRA) ctrl.alu_op = ALU_SRA;
                  else ctrl.unsupported = 1'b1;
               end
               F3_OR:   ctrl.alu_op = ALU_OR;
               default: ctrl.alu_op = ALU_AND;
            endcase
         end
         OP_IMM32: begin
            ctrl.b_sel_imm = 1'b1;
            if (funct3 == F3_ADD) begin
               ctrl.alu_op = ALU_ADDW;
            end else if (funct3 == F3_SLL && funct7 == F7_BASE) begin
               ctrl.alu_op = ALU_SLLW;
            end else if (funct3 == F3_SR && funct7 == F7_BASE) begin
               ctrl.alu_op = ALU_SRLW;
            end else if (funct3 == F3_SR && funct7 == F7_ALT) begin
               ctrl.alu_op = ALU_SRAW;
            end else begin
               ctrl.unsupported = 1'b1;
            end
         end
         OP_SYSTEM: begin
            // ecall, ebreak and csr ops are stubs returning zero
            if (funct3 == F3_SYS_RESERVED) ctrl.unsupported = 1'b1;
         end
         OP_LOAD, OP_STORE: begin
            ctrl.alu_op    = ALU_ADD;
            ctrl.b_sel_imm = 1'b1;
         end
         OP_BRANCH: begin
            case (funct3)
               F3_BEQ:  ctrl.br_cond = BR_EQ;
               F3_BNE:  ctrl.br_cond = BR_NE;
               F3_BLT:  ctrl.br_cond = BR_LT;
               F3_BGE:  ctrl.br_cond = BR_GE;
               F3_BLTU: ctrl.br_cond = BR_LTU;
               F3_BGEU: ctrl.br_cond = BR_GEU;
               default: ctrl.unsupported = 1'b1;
            endcase
         end
         OP_AUIPC: begin
            ctrl.alu_op    = ALU_ADD;
            ctrl.a_sel_pc  = 1'b1;
            ctrl.b_sel_imm = 1'b1;
         end
         OP_LUI: begin
            ctrl.alu_op    = ALU_PASS_B;
            ctrl.b_sel_imm = 1'b1;
         end
         OP_JAL: begin
            ctrl.alu_op   = ALU_LINK;
            ctrl.a_sel_pc = 1'b1;
         end
         default: begin
            ctrl.unsupported = 1'b1;
         end
      endcase
   end

endmodule

[sv/rvalu_datapath.sv]
`timescale 1ns / 1ps
module rvalu_datapath
   import rvalu_pkg::*;
(
   input  ctrl_type    ctrl,
   input  logic [63:0] src1_value,
   input  logic [63:0] src2_value,
   input  logic [63:0] imm_value,
   input  logic [63:0] pc_value,
   output rsp_type     rsp
);

   logic [63:0] op_a;
   logic [63:0] op_b;
   logic [5:0]  sh64;
   logic [4:0]  sh32;
   logic [63:0] sum;
   logic [63:0] diff;
   logic [31:0] word_sll;
   logic [31:0] word_srl;
   logic [31:0] word_sra;
   logic        lt_s;
   logic        lt_u;
   logic        eq;
   logic [63:0] result;
   logic        taken;

   assign op_a = ctrl.a_sel_pc  ? pc_value  : src1_value;
   assign op_b = ctrl.b_sel_imm ? imm_value : src2_value;
   assign sh64 = op_b[5:0];
   assign sh32 = op_b[4:0];

   assign sum      = op_a + op_b;
   assign diff     = op_a - op_b;
   assign word_sll = op_a[31:0] << sh32;
   assign word_srl = op_a[31:0] >> sh32;
   assign word_sra = 32'($signed(op_a[31:0]) >>> sh32);

   // compares use src1 so branches and set-less-than share them
   assign lt_s = $signed(src1_value) < $signed(op_b);
   assign lt_u = src1_value < op_b;
   assign eq   = src1_value == op_b;

   always_comb begin
      case (ctrl.alu_op)
         ALU_ADD:    result = sum;
         ALU_SUB:    result = diff;
         ALU_SLL:    result = op_a << sh64;
         ALU_SLT:    result = {63'd0, lt_s};
         ALU_SLTU:   result = {63'd0, lt_u};
         ALU_XOR:    result = op_a ^ op_b;
         ALU_SRL:    result = op_a >> sh64;
         ALU_SRA:    result = 64'($signed(op_a) >>> sh64);
         ALU_OR:     result = op_a | op_b;
         ALU_AND:    result = op_a & op_b;
         ALU_ADDW:   result = {{32{sum[31]}}, sum[31:0]};
         ALU_SUBW:   result = {{32{diff[31]}}, diff[31:0]};
         ALU_SLLW:   result = {{32{word_sll[31]}}, word_sll};
         ALU_SRLW:   result = {{32{word_srl[31]}}, word_srl};
         ALU_SRAW:   result = {{32{word_sra[31]}}, word_sra};
         ALU_PASS_B: result = op_b;
         ALU_LINK:   result = op_a + LINK_OFFSET;
         default:    result = 64'd0;
      endcase
   end

   always_comb begin
      case (ctrl.br_cond)
         BR_EQ:   taken = eq;
         BR_NE:   taken = !eq;
         BR_LT:   taken = lt_s;
         BR_GE:   taken = !lt_s;
         BR_LTU:  taken = lt_u;
         BR_GEU:  taken = !lt_u;
         default: taken = 1'b0;
      endcase
   end

   assign rsp.result_value = result;
   assign rsp.branch_taken = taken;
   assign rsp.unsupported  = ctrl.unsupported;

endmodule

[sv/rv64i_execute_alu.sv]
`timescale 1ns / 1ps
// RV64I execute stage: one instruction beat in, one result beat out, with a new
// beat accepted every cycle while req_stall is low. The path runs through an input
// register, then decode and the 64-bit adder/shifter/compare path, then the result
// register. Back-pressure on rsp_stall fills the two registers before req_stall
// rises, so no beat is lost or repeated.
module rv64i_execute_alu
   import rvalu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     s1_valid_ff;
   logic     s1_valid_in;
   req_type  s1_data_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   rsp_type  rsp_data_ff;
   logic     out_free;
   logic     s1_free;
   ctrl_type ctrl;
   rsp_type  rsp_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_stall = !s1_free;

   assign s1_valid_in  = s1_free ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_valid) s1_data_ff <= req_data;
      if (out_free && s1_valid_ff) rsp_data_ff <= rsp_next;
   end

   rvalu_decode u_decode (
      .instr_word (s1_data_ff.instr_word),
      .ctrl       (ctrl)
   );

   rvalu_datapath u_datapath (
      .ctrl       (ctrl),
      .src1_value (s1_data_ff.src1_value),
      .src2_value (s1_data_ff.src2_value),
      .imm_value  (s1_data_ff.imm_value),
      .pc_value   (s1_data_ff.pc_value),
      .rsp        (rsp_next)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // both stages full and output held: input must be stalled
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input accepted while pipeline is full");

   // a held item in the input register moves to the output when it is free
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free) |=> rsp_valid_ff)
      else $error("item lost between input and result register");

   // only a branch opcode can raise the taken flag
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free && s1_data_ff.instr_word[6:0] != OP_BRANCH)
      |=> !rsp_data_ff.branch_taken)
      else $error("branch taken on a non-branch op");

   // unsupported words give a zero result
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free && ctrl.unsupported)
      |=> (rsp_data_ff.result_value == 64'd0 && !rsp_data_ff.branch_taken))
      else $error("unsupported op produced nonzero result");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import rvalu_pkg::*;

   // jalr is decoded by nobody in this stage
   localparam logic [6:0] OPC_JALR = 7'h67;
   localparam int RANDOM_ITEMS = 1150;
   localparam int QUIET_FIRST  = 700;
   localparam int QUIET_LAST   = 900;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;

   class exec_scoreboard;
      rsp_type expected_q[$];
      int issued;
      int checked;
      int errors;
      int unsupported_seen;
      int taken_seen;

      function logic [63:0] word_result(logic [2:0] f3, logic alt, logic [63:0] a,
                                        logic [63:0] b);
         logic [31:0] w;
         logic signed [31:0] sw;
         case (f3)
            F3_ADD: w = alt ? a[31:0] - b[31:0] : a[31:0] + b[31:0];
            F3_SLL: w = a[31:0] << b[4:0];
            default: begin
               if (alt) begin
                  sw = a[31:0];
                  w = sw >>> b[4:0];
               end else begin
                  w = a[31:0] >> b[4:0];
               end
            end
         endcase
         return {{32{w[31]}}, w};
      endfunction

      function rsp_type exec_result(req_type r);
         logic [6:0] opc;
         logic [6:0] f7;
         logic [5:0] f6;
         logic [2:0] f3;
         logic [63:0] a;
         logic [63:0] b;
         logic [63:0] imm;
         logic [63:0] res;
         logic signed [63:0] s1;
         logic signed [63:0] s2;
         logic signed [63:0] si;
         logic taken;
         logic ok;
         rsp_type out;
         opc = r.instr_word[6:0];
         f3 = r.instr_word[14:12];
         f7 = r.instr_word[31:25];
         f6 = r.instr_word[31:26];
         a = r.src1_value;
         b = r.src2_value;
         imm = r.imm_value;
         s1 = a;
         s2 = b;
         si = imm;
         res = '0;
         taken = 1'b0;
         ok = 1'b1;
         case (opc)
            OP_REG: begin
               if (f7 == F7_BASE) begin
                  case (f3)
                     F3_ADD:  res = a + b;
                     F3_SLL:  res = a << b[5:0];
                     F3_SLT:  res = {63'b0, s1 < s2};
                     F3_SLTU: res = {63'b0, a < b};
                     F3_XOR:  res = a ^ b;
                     F3_SR:   res = a >> b[5:0];
                     F3_OR:   res = a | b;
                     default: res = a & b;
                  endcase
               end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                  res = a - b;
               end else if (f7 == F7_ALT && f3 == F3_SR) begin
                  res = s1 >>> b[5:0];
               end else begin
                  ok = 1'b0;
               end
            end
            OP_REG32: begin
               if (f7 == F7_BASE && (f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SR))
                  res = word_result(f3, 1'b0, a, b);
               else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))
                  res = word_result(f3, 1'b1, a, b);
               else
                  ok = 1'b0;
            end
            OP_IMM: begin
               case (f3)
                  F3_ADD: res = a + imm;
                  F3_SLL: begin
                     if (f6 == F6_BASE) res = a << imm[5:0];
                     else ok = 1'b0;
                  end
                  F3_SLT:  res = {63'b0, s1 < si};
                  F3_SLTU: res = {63'b0, a < imm};
                  F3_XOR:  res = a ^ imm;
                  F3_SR: begin
                     if (f6 == F6_BASE) res = a >> imm[5:0];
                     else if (f6 == F6_SRA) res = s1 >>> imm[5:0];
                     else ok = 1'b0;
                  end
                  F3_OR:   res = a | imm;
                  default: res = a & imm;
               endcase
            end
            OP_IMM32: begin
               if (f3 == F3_ADD)
                  res = word_result(F3_ADD, 1'b0, a, imm);
               else if (f3 == F3_SLL && f7 == F7_BASE)
                  res = word_result(F3_SLL, 1'b0, a, imm);
               else if (f3 == F3_SR && f7 == F7_BASE)
                  res = word_result(F3_SR, 1'b0, a, imm);
               else if (f3 == F3_SR && f7 == F7_ALT)
                  res = word_result(F3_SR, 1'b1, a, imm);
               else
                  ok = 1'b0;
            end
            OP_SYSTEM: begin
               if (f3 == F3_SYS_RESERVED) ok = 1'b0;
            end
            OP_LOAD, OP_STORE: res = a + imm;
            OP_BRANCH: begin
               case (f3)
                  F3_BEQ:  taken = (a == b);
                  F3_BNE:  taken = (a != b);
                  F3_BLT:  taken = (s1 < s2);
                  F3_BGE:  taken = !(s1 < s2);
                  F3_BLTU: taken = (a < b);
                  F3_BGEU: taken = (a >= b);
                  default: ok = 1'b0;
               endcase
            end
            OP_AUIPC: res = r.pc_value + imm;
            OP_LUI:   res = imm;
            OP_JAL:   res = r.pc_value + LINK_OFFSET;
            default:  ok = 1'b0;
         endcase
         if (!ok) begin
            res = '0;
            taken = 1'b0;
         end
         out.result_value = res;
         out.branch_taken = taken;
         out.unsupported = !ok;
         return out;
      endfunction

      function void note_issue(req_type r);
         expected_q.push_back(exec_result(r));
         issued++;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat, got %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.unsupported) unsupported_seen++;
         if (got.branch_taken) taken_seen++;
         if (got.result_value !== want.result_value) begin
            $display("%0t: result_value expected %h got %h", $time, want.result_value,
                     got.result_value);
            errors++;
         end
         if (got.branch_taken !== want.branch_taken) begin
            $display("%0t: branch_taken expected %b got %b", $time, want.branch_taken,
                     got.branch_taken);
            errors++;
         end
         if (got.unsupported !== want.unsupported) begin
            $display("%0t: unsupported expected %b got %b", $time, want.unsupported,
                     got.unsupported);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   exec_scoreboard sb = new();
   int items_offered = 0;

   rv64i_execute_alu uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_issue(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   function automatic bit in_quiet_window();
      return items_offered >= QUIET_FIRST && items_offered < QUIET_LAST;
   endfunction

   // receiver: random stalls, one long hold to back the block up, one quiet stretch
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && items_offered >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (in_quiet_window()) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 24);
         end
      end
   end

   task automatic send_item(input req_type item);
      while (!in_quiet_window() && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      items_offered++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_op(input logic [6:0] opc, input logic [2:0] f3, input logic [6:0] f7,
                          input logic [63:0] a, input logic [63:0] b,
                          input logic [63:0] imm, input logic [63:0] pc);
      req_type r;
      r.instr_word = $urandom;
      r.instr_word[6:0] = opc;
      r.instr_word[14:12] = f3;
      r.instr_word[31:25] = f7;
      r.src1_value = a;
      r.src2_value = b;
      r.imm_value = imm;
      r.pc_value = pc;
      send_item(r);
   endtask

   function automatic logic [63:0] rand_operand();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h7fff_ffff_ffff_ffff;
         4: return 64'($urandom_range(0, 63));
         5: return {{32{w[31]}}, w};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_req();
      logic [6:0] opcodes[11];
      logic [6:0] f7;
      req_type r;
      opcodes = '{OP_REG, OP_REG32, OP_IMM, OP_IMM32, OP_SYSTEM, OP_LOAD, OP_STORE,
                  OP_BRANCH, OP_AUIPC, OP_LUI, OP_JAL};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: f7 = F7_BASE;
         5, 6, 7:       f7 = F7_ALT;
         8:             f7 = F7_BASE | 7'h01;
         default:       f7 = 7'($urandom);
      endcase
      r.instr_word = $urandom;
      // a small share of raw words for noise, the rest with a known opcode and a chosen funct7
      if ($urandom_range(0, 99) >= 8) begin
         r.instr_word[6:0] = opcodes[$urandom_range(0, 10)];
         r.instr_word[31:25] = f7;
      end
      r.src1_value = rand_operand();
      r.src2_value = ($urandom_range(0, 7) == 0) ? r.src1_value : rand_operand();
      r.imm_value = rand_operand();
      r.pc_value = ($urandom_range(0, 3) == 0) ? rand_operand() : {$urandom, $urandom};
      return r;
   endfunction

   initial begin
      logic [63:0] ones;
      logic [63:0] msb;
      ones = '1;
      msb = 64'h8000_0000_0000_0000;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: edges of each op class
      send_op(OP_REG, F3_ADD, F7_BASE, ones, 64'd1, 0, 0);
      send_op(OP_REG, F3_ADD, F7_ALT, 64'd0, 64'd1, 0, 0);
      send_op(OP_REG, F3_SLL, F7_BASE, 64'd1, ones, 0, 0);
      send_op(OP_REG, F3_SR, F7_BASE, ones, 64'd127, 0, 0);
      send_op(OP_REG, F3_SR, F7_ALT, msb, 64'd63, 0, 0);
      send_op(OP_REG, F3_SLT, F7_BASE, msb, 64'd1, 0, 0);
      send_op(OP_REG, F3_SLTU, F7_BASE, 64'd1, msb, 0, 0);
      send_op(OP_REG, F3_XOR, F7_BASE, ones, 64'h5555_aaaa_0f0f_f0f0, 0, 0);
      send_op(OP_REG, F3_OR, F7_BASE, msb, 64'd1, 0, 0);
      send_op(OP_REG, F3_AND, F7_BASE, ones, msb, 0, 0);
      send_op(OP_REG, F3_ADD, F7_BASE | 7'h01, ones, ones, 0, 0);
      send_op(OP_REG32, F3_ADD, F7_BASE, 64'h7fff_ffff, 64'd1, 0, 0);
      send_op(OP_REG32, F3_ADD, F7_ALT, 64'd0, 64'd1, 0, 0);
      send_op(OP_REG32, F3_SLL, F7_BASE, 64'd1, 64'd63, 0, 0);
      send_op(OP_REG32, F3_SR, F7_BASE, ones, 64'd31, 0, 0);
      send_op(OP_REG32, F3_SR, F7_ALT, 64'h8000_0000, 64'd63, 0, 0);
      send_op(OP_IMM, F3_SLL, F7_BASE | 7'h01, 64'd1, 0, 64'd63, 0);
      send_op(OP_IMM, F3_SR, F7_ALT, msb, 0, 64'd63, 0);
      send_op(OP_IMM, F3_SR, 7'h40, ones, 0, 64'd1, 0);
      send_op(OP_IMM, F3_SLTU, 7'($urandom), 64'd5, 0, ones, 0);
      send_op(OP_IMM32, F3_SR, F7_ALT, 64'h8000_0000, 0, 64'd31, 0);
      send_op(OP_LOAD, F3_SLT, 7'($urandom), ones, 0, 64'd1, 0);
      send_op(OP_STORE, F3_ADD, 7'($urandom), 64'h1000, 0, ones, 0);
      send_op(OP_LUI, 3'($urandom), 7'($urandom), 0, 0, 64'hffff_ffff_8000_0000, 0);
      send_op(OP_AUIPC, 3'($urandom), 7'($urandom), 0, 0, ones, 64'd4);
      send_op(OP_JAL, 3'($urandom), 7'($urandom), 0, 0, 0, ones);
      send_op(OP_BRANCH, F3_BEQ, 7'($urandom), ones, ones, 0, 0);
      send_op(OP_BRANCH, F3_BGE, 7'($urandom), msb, msb, 0, 0);
      send_op(OP_BRANCH, F3_BLTU, 7'($urandom), 64'd1, msb, 0, 0);
      send_op(OP_BRANCH, F3_SLT, 7'($urandom), 64'd1, 64'd2, 0, 0);
      send_op(OP_SYSTEM, F3_SYS_RESERVED, 7'($urandom), ones, ones, ones, 0);
      send_op(OPC_JALR, F3_ADD, 7'($urandom), ones, ones, ones, ones);

      repeat (RANDOM_ITEMS) send_item(random_req());
      req_valid <= 1'b0;

      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("run covered %0d instruction beats, %0d results checked", sb.issued,
               sb.checked);
      $display("of those %0d unsupported and %0d branches taken, with a %0d-cycle hold",
               sb.unsupported_seen, sb.taken_seen, HOLD_CYCLES);
      if (sb.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", sb.pending());
      $display("testbench: done, errors");
      $finish;
   end

endmodule
